[design/prtd_pkg.sv]
// shared constants and controller/datapath interface types for the prime range tester
`default_nettype none

package prtd_pkg;

    // width of the candidate, echo and count fields
    localparam int FIELD_BITS = 16;

    // default width of the value under test
    localparam int VALUE_BITS_DEFAULT = 16;

    // remainder bits resolved per cycle by the shared divider
    localparam int DIV_STEPS = 4;

    // first odd trial divisor and its square
    localparam int DIV_FIRST = 3;
    localparam int SQ_FIRST  = 9;

    // saturation limit of the prime count
    localparam logic [FIELD_BITS-1:0] COUNT_MAX = '1;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture a new candidate
        logic div_start;  // begin a remainder computation for the current divisor
        logic div_step;   // resolve the next group of remainder bits
        logic div_next;   // advance to the next odd divisor
        logic finish;     // update the count and fill the output register
        logic verdict;    // prime decision that goes with finish
    } prtd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_low;     // value is 0 or 1
        logic is_two;     // value is 2
        logic is_even;    // value is even
        logic sq_gt_n;    // divisor squared exceeds the value
        logic div_last;   // current step is the final one of the remainder
        logic rem_zero;   // remainder is zero
    } prtd_status_t;

endpackage

`default_nettype wire

[design/prtd_in_if.sv]
// candidate channel: valid/ready handshake with the input item payload
`default_nettype none

interface prtd_in_if;
    import prtd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] candidate;
    logic                  first_in_range;
    logic                  last_in_range;

    modport source (output valid, output candidate, output first_in_range,
                    output last_in_range, input ready);
    modport sink   (input valid, input candidate, input first_in_range,
                    input last_in_range, output ready);
endinterface

`default_nettype wire

[design/prtd_out_if.sv]
// result channel: valid/ready handshake with the result item payload
`default_nettype none

interface prtd_out_if;
    import prtd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] tested_value;
    logic                  prime_flag;
    logic [FIELD_BITS-1:0] prime_count;
    logic                  range_done;

    modport source (output valid, output tested_value, output prime_flag,
                    output prime_count, output range_done, input ready);
    modport sink   (input valid, input tested_value, input prime_flag,
                    input prime_count, input range_done, output ready);
endinterface

`default_nettype wire

[design/prtd_datapath.sv]
// datapath: value, divisor, square tracker, shared remainder unit, count and output register
`default_nettype none

module prtd_datapath #(
    parameter int VALUE_BITS = prtd_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire prtd_pkg::prtd_cmd_t             cmd,
    output prtd_pkg::prtd_status_t               status,
    input  wire logic [prtd_pkg::FIELD_BITS-1:0] candidate,
    input  wire logic                            first_in_range,
    input  wire logic                            last_in_range,
    output logic [prtd_pkg::FIELD_BITS-1:0]      tested_value,
    output logic                                 prime_flag,
    output logic [prtd_pkg::FIELD_BITS-1:0]      prime_count,
    output logic                                 range_done
);
    import prtd_pkg::*;

    localparam int SQ_W       = VALUE_BITS + 4;
    localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W      = DIV_CYCLES * DIV_STEPS;
    localparam int CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    logic [VALUE_BITS-1:0] value_reg;
    logic                  first_reg;
    logic                  last_reg;
    logic [VALUE_BITS-1:0] div_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [PAD_W-1:0]      shift_reg;
    logic [VALUE_BITS:0]   rem_reg;
    logic [VALUE_BITS:0]   rem_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [FIELD_BITS-1:0] count_reg;
    logic [FIELD_BITS-1:0] count_next;
    logic [FIELD_BITS-1:0] count_base;

    // several restoring division steps per cycle, dividend msb first
    always_comb
    begin
        logic [VALUE_BITS:0] trial;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial = {rem_next[VALUE_BITS-1:0], shift_reg[PAD_W-1-i]};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
            end
            else
            begin
                rem_next = trial;
            end
        end
    end

    // status toward the controller
    always_comb
    begin
        status.is_low   = (value_reg <= VALUE_BITS'(1));
        status.is_two   = (value_reg == VALUE_BITS'(2));
        status.is_even  = !value_reg[0];
        status.sq_gt_n  = (sq_reg > SQ_W'(value_reg));
        status.div_last = (cnt_reg == CNT_W'(DIV_CYCLES - 1));
        status.rem_zero = (rem_reg == '0);
    end

    // saturating running count, cleared by the first-of-range mark
    always_comb
    begin
        count_base = first_reg ? '0 : count_reg;
        count_next = count_base;
        if (cmd.verdict && (count_base != COUNT_MAX))
        begin
            count_next = count_base + FIELD_BITS'(1);
        end
    end

    // running count and divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
            if (cmd.div_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // candidate capture, divisor walk and remainder unit
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= VALUE_BITS'(candidate);
            first_reg <= first_in_range;
            last_reg  <= last_in_range;
            div_reg   <= VALUE_BITS'(DIV_FIRST);
            sq_reg    <= SQ_W'(SQ_FIRST);
        end
        else if (cmd.div_next)
        begin
            // (d+2)^2 = d^2 + 4d + 4
            div_reg <= div_reg + VALUE_BITS'(2);
            sq_reg  <= sq_reg + SQ_W'({div_reg, 2'b00}) + SQ_W'(4);
        end
        if (cmd.div_start)
        begin
            shift_reg <= PAD_W'(value_reg);
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            shift_reg <= shift_reg << DIV_STEPS;
            rem_reg   <= rem_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            tested_value <= FIELD_BITS'(value_reg);
            prime_flag   <= cmd.verdict;
            prime_count  <= count_next;
            range_done   <= last_reg;
        end
    end

endmodule

`default_nettype wire

[design/prtd_ctrl.sv]
// controller: sequences classification, divisor trials and result hand-off
`default_nettype none

module prtd_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire prtd_pkg::prtd_status_t status,
    output prtd_pkg::prtd_cmd_t         cmd
);
    import prtd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_TEST,
        S_DIV,
        S_REM,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   verdict_reg;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // command decode
    always_comb
    begin
        cmd         = '0;
        cmd.verdict = verdict_reg;
        unique case (state_reg)
            S_IDLE:     cmd.load      = in_valid;
            S_CLASSIFY: cmd.load      = 1'b0;
            S_TEST:     cmd.div_start = !status.sq_gt_n;
            S_DIV:      cmd.div_step  = 1'b1;
            S_REM:      cmd.div_next  = !status.rem_zero;
            S_FINISH:   cmd.finish    = !out_valid_reg || out_ready;
            default:    cmd.load      = 1'b0;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            verdict_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // output register fill and drain
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_CLASSIFY;
                    end
                end
                S_CLASSIFY:
                begin
                    if (status.is_two)
                    begin
                        verdict_reg <= 1'b1;
                        state_reg   <= S_FINISH;
                    end
                    else if (status.is_low || status.is_even)
                    begin
                        verdict_reg <= 1'b0;
                        state_reg   <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    if (status.sq_gt_n)
                    begin
                        verdict_reg <= 1'b1;
                        state_reg   <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (status.div_last)
                    begin
                        state_reg <= S_REM;
                    end
                end
                S_REM:
                begin
                    if (status.rem_zero)
                    begin
                        verdict_reg <= 1'b0;
                        state_reg   <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_TEST;
                    end
                end
                S_FINISH:
                begin
                    if (cmd.finish)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/prime_range_trial_division_unit.sv]
// Prime range tester: trial-division primality test on a stream of candidates.
//
// in_chan (sink) takes one candidate per transaction together with the
// first_in_range / last_in_range marks; out_chan (source) returns one result
// per candidate: the tested value, its prime flag, the running prime count of
// the range (cleared by first_in_range, saturating at all ones) and range_done.
// One candidate is worked on at a time. A candidate is classified in the
// classify state (0, 1, 2 and even values finish at once); an odd value then
// tries odd divisors d = 3, 5, ... while d*d <= value. Each divisor passes a
// test state, then divide steps in the shared remainder unit, which resolves
// four remainder bits per cycle, then a remainder check; trials stop at the
// first divisor that divides. For 16-bit values at most 127 divisors are tried.
// The next candidate is taken once the current result has moved into the
// output register, so a finished result may wait on a stalled receiver while
// a new candidate is already being tested; the tester only stalls when a
// second result is ready and the output register is still full.
// Reset (rst_n, asynchronous, active low) clears the prime count and empties
// the output register.
`default_nettype none

module prime_range_trial_division_unit #(
    parameter int VALUE_BITS = prtd_pkg::VALUE_BITS_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    prtd_in_if.sink  in_chan,
    prtd_out_if.source out_chan
);
    import prtd_pkg::*;

    prtd_cmd_t    cmd;
    prtd_status_t status;

    prtd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_chan.valid),
        .in_ready  (in_chan.ready),
        .out_valid (out_chan.valid),
        .out_ready (out_chan.ready),
        .status    (status),
        .cmd       (cmd)
    );

    prtd_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .candidate      (in_chan.candidate),
        .first_in_range (in_chan.first_in_range),
        .last_in_range  (in_chan.last_in_range),
        .tested_value   (out_chan.tested_value),
        .prime_flag     (out_chan.prime_flag),
        .prime_count    (out_chan.prime_count),
        .range_done     (out_chan.range_done)
    );

    // a result only enters the output register when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_chan.valid || out_chan.ready))
        else $error("result written over a pending transaction");

    // one candidate at a time: no new transaction right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
        else $error("input taken while a candidate is in work");

    // a prime result is odd or two
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && out_chan.prime_flag) |->
        (out_chan.tested_value[0] || (out_chan.tested_value == FIELD_BITS'(2))))
        else $error("even value other than two flagged prime");

    // a new result always comes from a finish command
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_chan.valid) |-> $past(cmd.finish))
        else $error("result transaction without a finish");

endmodule

`default_nettype wire
